>>> sv/fwsd_pkg.sv
// Shared types, constants and the arctangent table for the steering model block.
`timescale 1ns / 1ps
package fwsd_pkg;

    // CORDIC datapath widths
    localparam int XW = 34;   // x and y lanes, signed
    localparam int ZW = 20;   // angle lane, signed Q16

    localparam logic signed [XW-1:0] ATAN_X0  = XW'(34'sd33554432);  // 2^25
    localparam logic signed [XW-1:0] COS_GAIN = XW'(34'sd652032875); // 0.60725 in Q30
    localparam logic [30:0]          SAT31    = 31'h7fff_ffff;
    localparam logic [33:0]          SEC_REM0 = 34'd8388608;         // 2^54 >> 31
    localparam logic [33:0]          SEC_SATC = 34'd8388608;         // c2 at or below saturates

    // configuration register indexes
    localparam logic CFG_WHEELBASE   = 1'b0;
    localparam logic CFG_STEER_LIMIT = 1'b1;

    // per item data that rides beside the arithmetic units
    typedef struct packed {
        logic               vneg;
        logic [14:0]        vmag;
        logic [15:0]        dt;
        logic [45:0]        vdt2;
        logic               pneg;
        logic               pzero;
        logic signed [15:0] steer_ref;
        logic [14:0]        dmag;
        logic               dneg;
        logic               sat;
    } t_side;

    // round(atan(2^-i) * 2^16)
    function automatic logic signed [ZW-1:0] fwsd_atan(input logic [4:0] i);
        logic signed [ZW-1:0] a;
        case (i)
            5'd0:    a = ZW'(51472);
            5'd1:    a = ZW'(30386);
            5'd2:    a = ZW'(16055);
            5'd3:    a = ZW'(8150);
            5'd4:    a = ZW'(4091);
            5'd5:    a = ZW'(2047);
            5'd6:    a = ZW'(1024);
            5'd7:    a = ZW'(512);
            5'd8:    a = ZW'(256);
            5'd9:    a = ZW'(128);
            5'd10:   a = ZW'(64);
            5'd11:   a = ZW'(32);
            5'd12:   a = ZW'(16);
            5'd13:   a = ZW'(8);
            5'd14:   a = ZW'(4);
            5'd15:   a = ZW'(2);
            5'd16:   a = ZW'(1);
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

>>> sv/fwsd_ifs.sv
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
interface fwsd_in_if;
    logic               valid;
    logic               ready;
    logic signed [14:0] velocity;
    logic signed [17:0] curvature;
    logic [15:0]        time_step;

    modport source (output valid, velocity, curvature, time_step, input ready);
    modport sink   (input valid, velocity, curvature, time_step, output ready);
endinterface

interface fwsd_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] a_upper_right;
    logic signed [31:0] b_first;
    logic signed [31:0] b_second;
    logic signed [31:0] w_first;
    logic signed [31:0] w_second;
    logic signed [15:0] steer_reference;

    modport source (output valid, a_upper_right, b_first, b_second, w_first, w_second,
                    steer_reference, input ready);
    modport sink   (input valid, a_upper_right, b_first, b_second, w_first, w_second,
                    steer_reference, output ready);
endinterface

>>> sv/fwsd_cordic.sv
// Unrolled CORDIC, one micro-rotation per register stage (vectoring or rotation mode).
`timescale 1ns / 1ps
module fwsd_cordic
    import fwsd_pkg::*;
#(
    parameter int STEPS = 16,
    parameter bit VECT  = 1'b1
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [XW-1:0] i_x,
    input  logic signed [XW-1:0] i_y,
    input  logic signed [ZW-1:0] i_z,
    output logic signed [XW-1:0] o_x,
    output logic signed [ZW-1:0] o_z
);

    logic signed [XW-1:0] r_x [STEPS];
    logic signed [XW-1:0] r_y [STEPS];
    logic signed [ZW-1:0] r_z [STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_step
        logic signed [XW-1:0] w_xi, w_yi, w_xs, w_ys;
        logic signed [ZW-1:0] w_zi, w_ang;
        logic                 w_pos;

        if (g == 0) begin : g_first
            assign w_xi = i_x;
            assign w_yi = i_y;
            assign w_zi = i_z;
        end else begin : g_next
            assign w_xi = r_x[g-1];
            assign w_yi = r_y[g-1];
            assign w_zi = r_z[g-1];
        end

        assign w_xs  = w_xi >>> g;
        assign w_ys  = w_yi >>> g;
        assign w_ang = fwsd_atan(5'(g));
        // vectoring drives y to zero, rotation drives z to zero
        assign w_pos = VECT ? (w_yi >= 0) : (w_zi >= 0);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (VECT == w_pos) begin
                    r_x[g] <= w_xi + w_ys;
                    r_y[g] <= w_yi - w_xs;
                    r_z[g] <= w_zi + w_ang;
                end else begin
                    r_x[g] <= w_xi - w_ys;
                    r_y[g] <= w_yi + w_xs;
                    r_z[g] <= w_zi - w_ang;
                end
            end
        end
    end

    assign o_x = r_x[STEPS-1];
    assign o_z = r_z[STEPS-1];

endmodule

>>> sv/fwsd_div.sv
// Pipelined restoring divider, one quotient bit per register stage.
`timescale 1ns / 1ps
module fwsd_div #(
    parameter int QW = 31,
    parameter int DW = 34
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [DW-1:0] i_rem,   // starting partial remainder, below i_den
    input  logic [QW-1:0] i_num,   // numerator bits shifted in, msb first
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [DW-1:0] r_r [QW];
    logic [QW-1:0] r_n [QW];   // remaining numerator on top, quotient fills from bottom
    logic [DW-1:0] r_d [QW];

    for (genvar g = 0; g < QW; g++) begin : g_step
        logic [DW-1:0] w_ri, w_di;
        logic [QW-1:0] w_ni;
        logic [DW:0]   w_t;
        logic          w_ge;

        if (g == 0) begin : g_first
            assign w_ri = i_rem;
            assign w_ni = i_num;
            assign w_di = i_den;
        end else begin : g_next
            assign w_ri = r_r[g-1];
            assign w_ni = r_n[g-1];
            assign w_di = r_d[g-1];
        end

        assign w_t  = {w_ri, w_ni[QW-1]};
        assign w_ge = w_t >= {1'b0, w_di};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_r[g] <= w_ge ? DW'(w_t - {1'b0, w_di}) : w_t[DW-1:0];
                r_n[g] <= {w_ni[QW-2:0], w_ge};
                r_d[g] <= w_di;
            end
        end
    end

    assign o_quo = r_n[QW-1];

endmodule

>>> sv/fwsd_mulsh.sv
// Wide unsigned product split in four partials, rounded shift, saturate and sign.
`timescale 1ns / 1ps
module fwsd_mulsh
    import fwsd_pkg::*;
#(
    parameter int WA = 16,
    parameter int WB = 16,
    parameter int SH = 8
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [WA-1:0]      i_a,
    input  logic [WB-1:0]      i_b,
    input  logic               i_neg,
    output logic signed [31:0] o_q
);

    localparam int HA = WA / 2;
    localparam int GA = WA - HA;
    localparam int HB = WB / 2;
    localparam int GB = WB - HB;
    localparam int WP = WA + WB;
    localparam logic [WP:0] HALF = (WP+1)'(1) << (SH - 1);

    logic [HA+HB-1:0] r_ll;
    logic [HA+GB-1:0] r_lh;
    logic [GA+HB-1:0] r_hl;
    logic [GA+GB-1:0] r_hh;
    logic [HA+WB-1:0] r_sa;
    logic [GA+WB-1:0] r_sb;
    logic [WP:0]      r_r;
    logic [2:0]       r_neg;
    logic signed [31:0] r_q;

    logic [WP+32:0] w_rx;
    logic           w_sat;
    logic [30:0]    w_mag;

    // stage 1: partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ll <= i_a[HA-1:0]  * i_b[HB-1:0];
            r_lh <= i_a[HA-1:0]  * i_b[WB-1:HB];
            r_hl <= i_a[WA-1:HA] * i_b[HB-1:0];
            r_hh <= i_a[WA-1:HA] * i_b[WB-1:HB];
            r_neg[0] <= i_neg;
        end
    end

    // stage 2: a halves times full b
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sa <= (HA+WB)'(r_ll) + ((HA+WB)'(r_lh) << HB);
            r_sb <= (GA+WB)'(r_hl) + ((GA+WB)'(r_hh) << HB);
            r_neg[1] <= r_neg[0];
        end
    end

    // stage 3: full product, round half up on the magnitude, shift
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_r <= ((WP+1)'(r_sa) + ((WP+1)'(r_sb) << HA) + HALF) >> SH;
            r_neg[2] <= r_neg[1];
        end
    end

    // stage 4: saturate and apply sign
    assign w_rx  = (WP+33)'(r_r);
    assign w_sat = w_rx > (WP+33)'(SAT31);
    assign w_mag = w_sat ? SAT31 : r_r[30:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= r_neg[2] ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});
        end
    end

    assign o_q = r_q;

endmodule

>>> sv/four_wheel_steer_model_discretize.sv
// Top level: discretized four-wheel-steering kinematic model, fully pipelined.
//
// Usage:
//   i_in carries one path point per beat (velocity, curvature, time step);
//   o_out carries the discrete model entries and the unclamped steer angle.
//   Both are valid/ready channels; a beat moves when valid and ready are high.
//   Every input beat gives exactly one output beat, in order.
//   Each beat passes the atan and cos CORDIC chains, the 31-stage sec^2
//   divider, the 46-stage gain divider and the 4-stage output multipliers.
//   Throughput is one beat per cycle while o_out.ready is high.
//   When the receiver stalls with a result waiting, the whole pipeline holds
//   and i_in.ready drops; bubbles are not squeezed out, nothing is lost.
//   Configuration (wheelbase, steer limit) is written through i_cfg_we /
//   i_cfg_idx / i_cfg_data; the user must write it only while no item is
//   in flight, which the block does not enforce. Synchronous active-low
//   reset empties the pipeline, loads defaults wheelbase 717, steer limit 9830.
`timescale 1ns / 1ps
module four_wheel_steer_model_discretize
    import fwsd_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [14:0] i_cfg_data,
    fwsd_in_if.sink     i_in,
    fwsd_out_if.source  o_out
);

    localparam int S   = CORDIC_STEPS;
    localparam int LAT = 2 * S + 88;

    // configuration
    logic [10:0] r_wb;
    logic [14:0] r_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb  <= 11'd717;
            r_lim <= 15'd9830;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WHEELBASE:   r_wb  <= i_cfg_data[10:0];
                CFG_STEER_LIMIT: r_lim <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves unless a finished beat is held
    logic           w_en;
    logic [LAT-1:0] r_vld;

    assign w_en       = ~r_vld[LAT-1] | o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    // stage 1: L*|k| and |v|*dt
    logic [14:0] w_vmag;
    logic [17:0] w_kmag;
    logic [28:0] r_s1_pmag;
    logic [29:0] r_s1_vdt;
    t_side       n_s1;
    t_side       r_s1;

    assign w_vmag = i_in.velocity[14]  ? 15'(-i_in.velocity)  : 15'(i_in.velocity);
    assign w_kmag = i_in.curvature[17] ? 18'(-i_in.curvature) : 18'(i_in.curvature);

    always_comb begin
        n_s1       = '0;
        n_s1.vneg  = i_in.velocity[14];
        n_s1.vmag  = w_vmag;
        n_s1.dt    = i_in.time_step;
        n_s1.pneg  = i_in.curvature[17];
        n_s1.pzero = (r_wb == '0) || (w_kmag == '0);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s1_pmag <= r_wb * w_kmag;
            r_s1_vdt  <= w_vmag * i_in.time_step;
            r_s1      <= n_s1;
        end
    end

    // atan CORDIC, side data alongside (vdt2 formed on the way in)
    logic signed [ZW-1:0] w_atan_z;
    t_side                n_sa0;
    t_side                r_sa [S];

    fwsd_cordic #(.STEPS(S), .VECT(1'b1)) u_atan (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (ATAN_X0),
        .i_y   (XW'(r_s1_pmag)),
        .i_z   ('0),
        .o_x   (),
        .o_z   (w_atan_z)
    );

    always_comb begin
        n_sa0      = r_s1;
        n_sa0.vdt2 = r_s1_vdt * r_s1.dt;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sa[0] <= n_sa0;
            for (int j = 1; j < S; j++) begin
                r_sa[j] <= r_sa[j-1];
            end
        end
    end

    // stage 2: Q16 to Q14, round half away from zero, restore sign
    logic signed [ZW-1:0] w_zr, w_zs;
    t_side                n_s2;
    t_side                r_s2;

    assign w_zr = (w_atan_z < 0) ? -((-w_atan_z + ZW'(2)) >>> 2) : ((w_atan_z + ZW'(2)) >>> 2);
    assign w_zs = r_sa[S-1].pzero ? '0 : (r_sa[S-1].pneg ? -w_zr : w_zr);

    always_comb begin
        n_s2           = r_sa[S-1];
        n_s2.steer_ref = 16'(w_zs);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s2 <= n_s2;
        end
    end

    // stage 3: clamp to the steer limit
    logic [15:0] w_amag;
    t_side       n_s3;
    t_side       r_s3;

    assign w_amag = r_s2.steer_ref[15] ? 16'(-r_s2.steer_ref) : 16'(r_s2.steer_ref);

    always_comb begin
        n_s3      = r_s2;
        n_s3.dneg = r_s2.steer_ref[15];
        n_s3.dmag = (w_amag >= {1'b0, r_lim}) ? r_lim : w_amag[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s3 <= n_s3;
        end
    end

    // cos CORDIC on |delta|
    logic signed [XW-1:0] w_cos_x;
    t_side                r_sb [S];

    fwsd_cordic #(.STEPS(S), .VECT(1'b0)) u_cos (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_x   (COS_GAIN),
        .i_y   ('0),
        .i_z   (ZW'({r_s3.dmag, 2'b00})),
        .o_x   (w_cos_x),
        .o_z   ()
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sb[0] <= r_s3;
            for (int j = 1; j < S; j++) begin
                r_sb[j] <= r_sb[j-1];
            end
        end
    end

    // stage 4: cos^2 in Q30
    logic [31:0] w_c;
    logic [63:0] w_cc;
    logic [33:0] r_s4_c2;
    t_side       r_s4;

    assign w_c  = (w_cos_x < XW'(1)) ? 32'd1 : w_cos_x[31:0];
    assign w_cc = w_c * w_c + 64'd536870912;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4_c2 <= w_cc[63:30];
            r_s4    <= r_sb[S-1];
        end
    end

    // sec^2 = 2^54 / c2, saturating when c2 is small
    logic [30:0] w_sec_q;
    t_side       n_sc0;
    t_side       r_sc [31];

    fwsd_div #(.QW(31), .DW(34)) u_sec (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem (SEC_REM0),
        .i_num ('0),
        .i_den (r_s4_c2),
        .o_quo (w_sec_q)
    );

    always_comb begin
        n_sc0     = r_s4;
        n_sc0.sat = r_s4_c2 <= SEC_SATC;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sc[0] <= n_sc0;
            for (int j = 1; j < 31; j++) begin
                r_sc[j] <= r_sc[j-1];
            end
        end
    end

    // stage 5: numerator 2*|v|*sec^2
    logic [30:0] w_sec2;
    logic [45:0] r_s5_num;
    logic [10:0] r_s5_wb;
    t_side       r_s5;

    assign w_sec2 = r_sc[30].sat ? SAT31 : w_sec_q;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s5_num <= {45'(r_sc[30].vmag * w_sec2), 1'b0};
            r_s5_wb  <= (r_wb == '0) ? 11'd1 : r_wb;
            r_s5     <= r_sc[30];
        end
    end

    // gain magnitude = numerator / L
    logic [45:0] w_gmag;
    t_side       r_sd [46];

    fwsd_div #(.QW(46), .DW(11)) u_gain (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_rem ('0),
        .i_num (r_s5_num),
        .i_den (r_s5_wb),
        .o_quo (w_gmag)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sd[0] <= r_s5;
            for (int j = 1; j < 46; j++) begin
                r_sd[j] <= r_sd[j-1];
            end
        end
    end

    // stages 6 and 7: gain, then gain * |delta|
    logic [45:0] r_s6_gmag, r_s7_gmag;
    logic [60:0] r_s7_gdmag;
    t_side       r_s6, r_s7;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s6_gmag  <= w_gmag;
            r_s6       <= r_sd[45];
            r_s7_gmag  <= r_s6_gmag;
            r_s7_gdmag <= r_s6_gmag * r_s6.dmag;
            r_s7       <= r_s6;
        end
    end

    // output products, rounded and saturated
    logic signed [31:0] w_a01, w_b0, w_b1, w_w0, w_w1;

    fwsd_mulsh #(.WA(15), .WB(16), .SH(8)) u_a01 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_s7.vmag), .i_b (r_s7.dt), .i_neg (r_s7.vneg), .o_q (w_a01)
    );

    fwsd_mulsh #(.WA(46), .WB(46), .SH(49)) u_b0 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_s7_gmag), .i_b (r_s7.vdt2), .i_neg (1'b0), .o_q (w_b0)
    );

    fwsd_mulsh #(.WA(46), .WB(16), .SH(24)) u_b1 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_s7_gmag), .i_b (r_s7.dt), .i_neg (r_s7.vneg), .o_q (w_b1)
    );

    // w terms carry the opposite sign of delta (w0) and of v*delta (w1)
    fwsd_mulsh #(.WA(61), .WB(46), .SH(63)) u_w0 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_s7_gdmag), .i_b (r_s7.vdt2), .i_neg (~r_s7.dneg), .o_q (w_w0)
    );

    fwsd_mulsh #(.WA(61), .WB(16), .SH(38)) u_w1 (
        .i_clk (i_clk), .i_en (w_en),
        .i_a (r_s7_gdmag), .i_b (r_s7.dt), .i_neg (r_s7.vneg == r_s7.dneg), .o_q (w_w1)
    );

    // steer reference follows the multiplier latency
    logic signed [15:0] r_se [4];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_se[0] <= r_s7.steer_ref;
            for (int j = 1; j < 4; j++) begin
                r_se[j] <= r_se[j-1];
            end
        end
    end

    assign o_out.valid           = r_vld[LAT-1];
    assign o_out.a_upper_right   = w_a01;
    assign o_out.b_first         = w_b0;
    assign o_out.b_second        = w_b1;
    assign o_out.w_first         = w_w0;
    assign o_out.w_second        = w_w1;
    assign o_out.steer_reference = r_se[3];

endmodule
